FILE: design/llh_pkg.sv
package llh_pkg;

    localparam int BINS_DEFAULT = 1024;
    localparam int IN_CNT_W   = 32;
    localparam int CUM_CNT_W  = 48;
    localparam int TOT_W      = 48;
    localparam int VAL_W      = 16;
    localparam int SCALE_W    = 24;
    localparam int PCT_W      = 14;
    localparam int BIN_OUT_W  = 10;
    localparam int ACT_W      = 2;
    localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd2523136;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [ACT_W-1:0] {
        ACT_UPDATE     = 2'd0,
        ACT_INTERVAL   = 2'd1,
        ACT_CUMULATIVE = 2'd2,
        ACT_CHECKPOINT = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        REG_LOG_MIN   = 1'b0,
        REG_BIN_SCALE = 1'b1
    } reg_index_t;

    // front-to-back queue entry
    typedef struct packed {
        action_t           action;
        logic [VAL_W:0]    diff;
        logic [PCT_W-1:0]  pct;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_TGT_MUL,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_SCAN_WR,
        ST_CLR,
        ST_DONE
    } state_t;

endpackage

FILE: design/llh_if.sv
interface llh_in_if;
    import llh_pkg::*;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic signed [VAL_W-1:0] log_value;
    logic [PCT_W-1:0]  percentile_hundredths;
    modport source (output valid, action, log_value, percentile_hundredths, input ready);
    modport sink   (input valid, action, log_value, percentile_hundredths, output ready);
endinterface

interface llh_out_if;
    import llh_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [BIN_OUT_W-1:0] bin_index;
    logic [TOT_W-1:0]     events_counted;
    modport source (output valid, bin_index, events_counted, input ready);
    modport sink   (input valid, bin_index, events_counted, output ready);
endinterface

FILE: design/llh_front.sv
module llh_front (
    input  logic clk,
    input  logic rst_n,
    llh_in_if.sink in_ch,
    input  logic signed [llh_pkg::VAL_W-1:0] log_min,
    output logic q_valid,
    input  logic q_ready,
    output llh_pkg::cmd_t q_cmd
);
    import llh_pkg::*;

    // two-entry queue
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in        = '0;
        cmd_in.action = action_t'(in_ch.action);
        cmd_in.diff   = {in_ch.log_value[VAL_W-1], in_ch.log_value}
                      - {log_min[VAL_W-1], log_min};
        cmd_in.pct    = (in_ch.percentile_hundredths > PCT_FULL)
                      ? PCT_FULL : in_ch.percentile_hundredths;
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push    = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count slip");
endmodule

FILE: design/llh_back.sv
module llh_back #(
    parameter int BINS = llh_pkg::BINS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  llh_pkg::cmd_t q_cmd,
    input  logic [llh_pkg::SCALE_W-1:0] bin_scale,
    llh_out_if.source out_ch,
    output logic clearing
);
    import llh_pkg::*;

    localparam int BW   = $clog2(BINS);
    localparam int CW   = BW + 1;
    localparam int SC_W = VAL_W + 1 + SCALE_W + 1;
    localparam int PR_W = TOT_W + PCT_W;
    localparam int WS_W = CUM_CNT_W + BW + PCT_W + 1;

    logic [IN_CNT_W-1:0]  imem [BINS];
    logic [CUM_CNT_W-1:0] cmem [BINS];

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [BW-1:0] idx_reg, idx_next;
    logic [BW-1:0] hit_reg, hit_next;
    logic          found_reg, found_next;
    logic [TOT_W-1:0] itot_reg, itot_next, ctot_reg, ctot_next;
    logic [TOT_W-1:0] events_reg, events_next;
    logic [PR_W-1:0]  prod_reg, prod_next;
    logic [PR_W-1:0]  add10_reg, add10_next;
    logic [WS_W-1:0]  wsum_reg, wsum_next;
    logic [IN_CNT_W-1:0]  ird_reg;
    logic [CUM_CNT_W-1:0] crd_reg;
    logic [BW-1:0]    rd_addr;
    logic             iwe, cwe;
    logic [BW-1:0]    waddr;
    logic [IN_CNT_W-1:0]  iwd;
    logic [CUM_CNT_W-1:0] cwd;
    logic [SC_W-1:0]  scaled;
    logic [SC_W-1:0]  scaled_reg;
    logic             ovalid_reg, ovalid_next;
    logic [BIN_OUT_W-1:0] obin_reg, obin_next;
    logic [TOT_W-1:0] oev_reg, oev_next;
    logic [CW-1:0]    clr_reg, clr_next;
    logic [CUM_CNT_W:0] fsum;
    logic [CUM_CNT_W-1:0] fold_val;
    logic [TOT_W:0]  tsum;
    logic [BW-1:0]  ubin;
    logic [TOT_W-1:0] addend;
    logic           take;

    assign clearing = (clr_reg != CW'(BINS));
    assign take     = q_valid && q_ready;
    assign q_ready  = (state_reg == ST_IDLE) && !clearing;

    // update bin: diff (17b signed) * scale (24b) + 2^25, >> 26, clamp
    assign scaled = SC_W'($signed(q_cmd.diff)) * SC_W'($signed({1'b0, bin_scale}))
                  + (SC_W'(1) << 25);
    always_comb
    begin
        if (scaled_reg[SC_W-1])
            ubin = '0;
        else if (scaled_reg[SC_W-2:26] >= (SC_W-27)'(BINS))
            ubin = BW'(BINS - 1);
        else
            ubin = scaled_reg[26 +: BW];
    end

    assign fsum     = {1'b0, crd_reg} + (CUM_CNT_W+1)'(ird_reg);
    assign fold_val = fsum[CUM_CNT_W] ? MASK48 : fsum[CUM_CNT_W-1:0];
    assign tsum     = {1'b0, ctot_reg} + {1'b0, itot_reg};
    always_comb
    begin
        if (cmd_reg.action == ACT_INTERVAL)
            addend = TOT_W'(ird_reg);
        else
            addend = TOT_W'(fold_val);
    end

    always_comb
    begin
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:     if (take)
                         begin
                             if (q_cmd.action == ACT_UPDATE) state_next = ST_UPD_RD;
                             else                            state_next = ST_TGT_MUL;
                         end
            ST_UPD_RD:   state_next = ST_UPD_WR;
            ST_UPD_WR:   state_next = ST_DONE;
            ST_TGT_MUL:  state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_ACC;
            ST_SCAN_ACC: state_next = ST_SCAN_WR;
            ST_SCAN_WR:  if (idx_reg == BW'(BINS - 1)) state_next = ST_DONE;
                         else                          state_next = ST_SCAN_RD;
            ST_DONE:     if (!ovalid_reg || out_ch.ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        itot_next   = itot_reg;
        ctot_next   = ctot_reg;
        events_next = events_reg;
        prod_next   = prod_reg;
        add10_next  = add10_reg;
        wsum_next   = wsum_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg;
        obin_next   = obin_reg;
        oev_next    = oev_reg;
        iwe = 1'b0;
        cwe = 1'b0;
        waddr = idx_reg;
        iwd = '0;
        cwd = '0;
        rd_addr = idx_reg;
        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;
        if (clearing)
        begin
            iwe = 1'b1;
            cwe = 1'b1;
            waddr = clr_reg[BW-1:0];
            clr_next = clr_reg + CW'(1);
        end
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                hit_next = BW'(BINS - 1);
                found_next = 1'b0;
                // running sum kept as 10000*sum + 4999, compared against total*p
                wsum_next = WS_W'(PCT_FULL / 14'd2) - WS_W'(1);
                if (take && q_cmd.action != ACT_UPDATE)
                begin
                    if (q_cmd.action == ACT_INTERVAL)
                        events_next = itot_reg;
                    else
                        events_next = tsum[TOT_W] ? MASK48 : tsum[TOT_W-1:0];
                end
            end
            ST_UPD_RD:
            begin
                idx_next = ubin;
                rd_addr  = ubin;
                itot_next = (itot_reg == MASK48) ? itot_reg : itot_reg + TOT_W'(1);
            end
            ST_UPD_WR:
            begin
                iwe = 1'b1;
                iwd = (ird_reg == '1) ? ird_reg : ird_reg + IN_CNT_W'(1);
            end
            ST_TGT_MUL:
                prod_next = PR_W'(events_reg) * PR_W'(cmd_reg.pct);
            ST_SCAN_RD: ;
            ST_SCAN_ACC:
                add10_next = PR_W'(addend) * PR_W'(PCT_FULL);
            ST_SCAN_WR:
            begin
                wsum_next = wsum_reg + WS_W'(add10_reg);
                if (!found_reg && wsum_next >= WS_W'(prod_reg))
                begin
                    found_next = 1'b1;
                    hit_next = idx_reg;
                end
                iwe = 1'b1;
                iwd = '0;
                cwe = 1'b1;
                cwd = (cmd_reg.action == ACT_CHECKPOINT) ? '0 : fold_val;
                idx_next = idx_reg + BW'(1);
                if (idx_reg == BW'(BINS - 1))
                begin
                    itot_next = '0;
                    if (cmd_reg.action == ACT_CHECKPOINT)
                        ctot_next = '0;
                    else
                        ctot_next = tsum[TOT_W] ? MASK48 : tsum[TOT_W-1:0];
                end
            end
            ST_DONE:
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    if (cmd_reg.action == ACT_UPDATE)
                    begin
                        obin_next = BIN_OUT_W'(idx_reg);
                        oev_next  = '0;
                    end
                    else
                    begin
                        obin_next = BIN_OUT_W'(hit_reg);
                        oev_next  = events_reg;
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (iwe)
            imem[waddr] <= iwd;
        if (cwe)
            cmem[waddr] <= cwd;
        ird_reg <= imem[rd_addr];
        crd_reg <= cmem[rd_addr];
        if (take)
        begin
            cmd_reg    <= q_cmd;
            scaled_reg <= scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            hit_reg    <= '0;
            found_reg  <= 1'b0;
            itot_reg   <= '0;
            ctot_reg   <= '0;
            events_reg <= '0;
            prod_reg   <= '0;
            add10_reg  <= '0;
            wsum_reg   <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            obin_reg   <= '0;
            oev_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            hit_reg    <= hit_next;
            found_reg  <= found_next;
            itot_reg   <= itot_next;
            ctot_reg   <= ctot_next;
            events_reg <= events_next;
            prod_reg   <= prod_next;
            add10_reg  <= add10_next;
            wsum_reg   <= wsum_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            obin_reg   <= obin_next;
            oev_reg    <= oev_next;
        end
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.bin_index      = obin_reg;
    assign out_ch.events_counted = oev_reg;

    a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == ST_IDLE) else $error("request taken while busy");
    a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_ready) else $error("request taken during clear");
    a_upd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && cmd_reg.action == ACT_UPDATE
         && (!ovalid_reg || out_ch.ready)) |=> oev_reg == '0)
        else $error("update events nonzero");
endmodule

FILE: design/log_latency_histogram_percentile_core.sv
// channel   dir  payload
// in_ch     in   action, log_value, percentile_hundredths
// out_ch    out  bin_index, events_counted
// apb       in   log_min @0x0, bin_scale @0x4
// Update: back-end steps are take, memory read, write, result; the next request waits for idle.
// Query: target multiply, then a read/add/write sweep of both
// count memories, bin by bin; the percentile compare rides the sweep.
// After reset a clearing pass over all bins runs before the back end takes any request.
// A two-entry queue splits intake from the back end; result holds under stall.
module log_latency_histogram_percentile_core #(
    parameter int BINS = llh_pkg::BINS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    llh_in_if.sink    in_ch,
    llh_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import llh_pkg::*;

    logic signed [VAL_W-1:0] log_min_reg;
    logic [SCALE_W-1:0]      bin_scale_reg;
    logic   q_valid, q_ready, clearing;
    cmd_t   q_cmd;
    logic   wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_min_reg   <= '0;
            bin_scale_reg <= SCALE_RESET;
        end
        else if (wr)
        begin
            case (reg_index_t'(paddr[2]))
                REG_LOG_MIN:   log_min_reg   <= pwdata[VAL_W-1:0];
                REG_BIN_SCALE: bin_scale_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_LOG_MIN:   prdata = {{(32-VAL_W){log_min_reg[VAL_W-1]}}, log_min_reg};
            REG_BIN_SCALE: prdata = {{(32-SCALE_W){1'b0}}, bin_scale_reg};
            default:       prdata = '0;
        endcase
    end

    llh_front u_front (
        .clk, .rst_n, .in_ch,
        .log_min(log_min_reg),
        .q_valid, .q_ready, .q_cmd
    );

    llh_back #(.BINS(BINS)) u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
        .bin_scale(bin_scale_reg),
        .out_ch, .clearing
    );
endmodule

FILE: tb/sv/llh_checker.sv
`timescale 1ns / 1ps

module llh_checker
    import llh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    llh_in_if           in_ch,
    llh_out_if          out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    localparam int NBINS = BINS_DEFAULT;

    typedef struct {
        logic [BIN_OUT_W-1:0] bin;
        logic [TOT_W-1:0]     events;
    } pct_result_t;

    pct_result_t result_q[$];

    logic [IN_CNT_W-1:0]  live_cnt[NBINS];
    logic [CUM_CNT_W-1:0] hist_cnt[NBINS];
    logic [TOT_W-1:0]     live_total;
    logic [TOT_W-1:0]     hist_total;
    logic signed [VAL_W-1:0] floor_log;
    logic [SCALE_W-1:0]   scale;

    function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MASK48 : s[47:0];
    endfunction

    function automatic logic [63:0] rank_target(logic [47:0] total, logic [PCT_W-1:0] p);
        logic [63:0] pp;
        pp = (p > PCT_FULL) ? 64'(PCT_FULL) : 64'(p);
        return (64'(total) * pp + 64'd5000) / 64'd10000;
    endfunction

    function automatic int bin_of(logic signed [VAL_W-1:0] v);
        longint d;
        longint prod;
        longint b;
        d = longint'(v) - longint'(floor_log);
        prod = d * longint'({40'b0, scale}) + (longint'(1) << 25);
        if (prod < 0)
            return 0;
        b = prod >>> 26;
        return (b >= NBINS) ? NBINS - 1 : int'(b);
    endfunction

    function automatic int find_rank(bit use_hist, logic [63:0] target);
        logic [63:0] run;
        run = 0;
        for (int i = 0; i < NBINS; i++)
        begin
            run += use_hist ? 64'(hist_cnt[i]) : 64'(live_cnt[i]);
            if (run >= target)
                return i;
        end
        return NBINS - 1;
    endfunction

    function automatic void fold_live();
        for (int i = 0; i < NBINS; i++)
        begin
            hist_cnt[i] = sat_add48(hist_cnt[i], 48'(live_cnt[i]));
            live_cnt[i] = '0;
        end
        hist_total = sat_add48(hist_total, live_total);
        live_total = '0;
    endfunction

    function automatic pct_result_t apply_request(action_t act, logic signed [VAL_W-1:0] v,
                                                  logic [PCT_W-1:0] p);
        pct_result_t r;
        int b;
        r.events = '0;
        case (act)
            ACT_UPDATE:
            begin
                b = bin_of(v);
                if (live_cnt[b] != '1)
                    live_cnt[b]++;
                live_total = sat_add48(live_total, 48'd1);
            end
            ACT_INTERVAL:
            begin
                r.events = live_total;
                b = find_rank(1'b0, rank_target(live_total, p));
                fold_live();
            end
            default:
            begin
                fold_live();
                r.events = hist_total;
                b = find_rank(1'b1, rank_target(hist_total, p));
                if (act == ACT_CHECKPOINT)
                begin
                    foreach (hist_cnt[i])
                        hist_cnt[i] = '0;
                    hist_total = '0;
                end
            end
        endcase
        r.bin = BIN_OUT_W'(b);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pct_result_t e;
        if (!rst_n)
        begin
            foreach (live_cnt[i])
                live_cnt[i] = '0;
            foreach (hist_cnt[i])
                hist_cnt[i] = '0;
            live_total = '0;
            hist_total = '0;
            floor_log = '0;
            scale = SCALE_RESET;
            result_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_index_t'(paddr[2]) == REG_LOG_MIN)
                    floor_log = pwdata[VAL_W-1:0];
                else
                    scale = pwdata[SCALE_W-1:0];
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result bin_index=%0d events_counted=%0d",
                           out_ch.bin_index, out_ch.events_counted);
                    errors++;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (out_ch.bin_index !== e.bin)
                    begin
                        $error("bin_index expected %0d actual %0d", e.bin, out_ch.bin_index);
                        errors++;
                    end
                    if (out_ch.events_counted !== e.events)
                    begin
                        $error("events_counted expected %0d actual %0d",
                               e.events, out_ch.events_counted);
                        errors++;
                    end
                end
            end
            // request accepted after the result check so ordering holds
            if (in_ch.valid && in_ch.ready)
                result_q.push_back(apply_request(action_t'(in_ch.action), in_ch.log_value,
                                                 in_ch.percentile_hundredths));
            pending = result_q.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import llh_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles;
    bit          gaps_on;

    llh_in_if  in_ch();
    llh_out_if out_ch();

    log_latency_histogram_percentile_core dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    llh_checker chk (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side stalls
    always @(negedge clk)
        out_ch.ready = gaps_on ? ($urandom_range(99) >= 8) : 1'b1;

    task automatic send(action_t act, logic [15:0] v, logic [13:0] p);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 8)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.action = act;
        in_ch.log_value = v;
        in_ch.percentile_hundredths = p;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        @(negedge clk);
        in_ch.valid = 1'b0;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr[2] = idx;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic random_items(int n, logic signed [15:0] lo);
        int roll;
        logic [15:0] v;
        logic [13:0] p;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 3)
                gaps_on = 1'b0;
            if (i == n / 2)
                gaps_on = 1'b1;
            roll = $urandom_range(99);
            v = ($urandom_range(1) == 0) ? 16'($urandom) : 16'(lo + $urandom_range(30000));
            p = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(10000));
            if (roll < 2)
                send(ACT_INTERVAL, v, p);
            else if (roll == 2)
                send(action_t'($urandom_range(2, 3)), v, p);
            else
                send(ACT_UPDATE, v, p);
            // occasionally hold off until the block has caught up
            if ($urandom_range(199) == 0)
                drain();
        end
        drain();
    endtask

    initial
    begin
        logic signed [15:0] mins[5];
        logic [23:0] scales[5];
        rst_n = 1'b0;
        gaps_on = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_UPDATE;
        in_ch.log_value = '0;
        in_ch.percentile_hundredths = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // wait for in_ch.ready after reset; the queue can fill during the clearing pass
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);

        // empty histogram: zero target
        send(ACT_INTERVAL, 16'h0, 14'd5000);
        send(ACT_CUMULATIVE, 16'h0, 14'd10000);
        send(ACT_UPDATE, 16'h8000, 14'd0);
        send(ACT_UPDATE, 16'h7FFF, 14'd0);
        send(ACT_UPDATE, 16'h0000, 14'd0);
        send(ACT_UPDATE, 16'd13, 14'd0);
        send(ACT_UPDATE, 16'd14, 14'd0);
        send(ACT_UPDATE, 16'd5000, 14'd0);
        send(ACT_UPDATE, 16'hFFFF, 14'd0);
        send(ACT_INTERVAL, 16'h0, 14'd0);
        send(ACT_UPDATE, 16'd27000, 14'd0);
        send(ACT_UPDATE, 16'd100, 14'd0);
        send(ACT_INTERVAL, 16'h0, 14'd10000);
        send(ACT_UPDATE, 16'd2000, 14'd0);
        send(ACT_CUMULATIVE, 16'h0, 14'd16383);
        send(ACT_UPDATE, 16'd300, 14'd0);
        send(ACT_CHECKPOINT, 16'h0, 14'd2500);
        send(ACT_CUMULATIVE, 16'h0, 14'd9999);
        send(ACT_UPDATE, 16'd300, 14'd0);
        send(ACT_CHECKPOINT, 16'hFFFF, 14'h2AAA);
        drain();
        random_items(370, 16'sd0);

        mins = '{-16'sd32768, 16'sd32767, -16'sd5120, 16'sd1024, 16'sd0};
        scales = '{24'hFFFFFF, 24'd0, 24'd65536, 24'd1, 24'h0};
        scales[4] = 24'($urandom_range(4000000));
        mins[4] = 16'($urandom);
        for (int ph = 0; ph < 5; ph++)
        begin
            reg_write(REG_LOG_MIN, {{16{mins[ph][15]}}, mins[ph]});
            reg_write(REG_BIN_SCALE, {8'h0, scales[ph]});
            random_items(ph == 4 ? 260 : 300, mins[ph]);
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
design/llh_pkg.sv
design/llh_if.sv
design/llh_front.sv
design/llh_back.sv
design/log_latency_histogram_percentile_core.sv
tb/sv/llh_checker.sv
tb/sv/tb.sv
